FILE: hdl/mecd_pkg.sv
// types, codes and constants shared by the character decoder modules
package mecd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned TakenW = 2;
  localparam int unsigned NeedW  = 3;

  localparam logic [CodeW-1:0] SuppBase = 21'h10000;

  typedef enum logic [1:0] {
    MODE_RAW      = 2'd0,
    MODE_UTF8     = 2'd1,
    MODE_UTF16_LE = 2'd2,
    MODE_UTF16_BE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_CHAR    = 2'd0,
    ST_INVALID = 2'd1,
    ST_END     = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0] code_point;
    status_e          status;
  } out_item_t;

  typedef struct packed {
    logic [TakenW-1:0] bytes_taken;
    logic [NeedW-1:0]  bytes_needed;
    logic [CodeW-1:0]  partial_value;
    logic              lead_unit_high_surrogate;
  } dec_state_t;

  localparam dec_state_t IdleState = '{
    bytes_taken:              '0,
    bytes_needed:             '0,
    partial_value:            '0,
    lead_unit_high_surrogate: 1'b0
  };

  localparam mode_e ModeReset = MODE_UTF8;

endpackage

FILE: hdl/mecd_step.sv
// per-byte decode step: next decoder state and the optional result
module mecd_step (
  input  mecd_pkg::mode_e      mode_i,
  input  mecd_pkg::dec_state_t state_i,
  input  mecd_pkg::in_item_t   item_i,
  output mecd_pkg::dec_state_t state_o,
  output logic                 emit_o,
  output mecd_pkg::out_item_t  result_o
);
  import mecd_pkg::*;

  logic [ByteW-1:0]  b;
  logic [TakenW-1:0] taken_inc;
  logic [CodeW-1:0]  cont_value;
  logic [15:0]       unit;
  logic [ByteW-1:0]  prev;
  logic [ByteW-1:0]  hi2;
  logic [ByteW-1:0]  lo2;
  logic              big;

  assign b          = item_i.data_byte;
  assign big        = (mode_i == MODE_UTF16_BE);
  assign taken_inc  = state_i.bytes_taken + 2'd1;
  assign cont_value = {state_i.partial_value[CodeW-7:0], b[5:0]};
  assign unit       = big ? {state_i.partial_value[7:0], b} : {b, state_i.partial_value[7:0]};
  assign prev       = state_i.partial_value[7:0];
  assign hi2        = big ? prev : b;
  assign lo2        = big ? b : prev;

  always_comb begin
    state_o             = state_i;
    emit_o              = 1'b0;
    result_o.code_point = '0;
    result_o.status     = ST_CHAR;

    if (item_i.end_of_data) begin
      emit_o = 1'b1;
      if (state_i.bytes_taken == '0) begin
        result_o.status = ST_END;
      end else begin
        result_o.status = ST_INVALID;
        state_o         = IdleState;
      end
    end else begin
      case (mode_i)
        MODE_RAW: begin
          state_o             = IdleState;
          emit_o              = 1'b1;
          result_o.code_point = {13'd0, b};
        end
        MODE_UTF8: begin
          if (state_i.bytes_taken == '0) begin
            if (!b[7]) begin
              emit_o              = 1'b1;
              result_o.code_point = {13'd0, b};
            end else if (b[7:5] == 3'b110) begin
              state_o.bytes_needed  = 3'd2;
              state_o.partial_value = {16'd0, b[4:0]};
              state_o.bytes_taken   = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
              state_o.bytes_needed  = 3'd3;
              state_o.partial_value = {17'd0, b[3:0]};
              state_o.bytes_taken   = 2'd1;
            end else if (b[7:3] == 5'b11110) begin
              state_o.bytes_needed  = 3'd4;
              state_o.partial_value = {18'd0, b[2:0]};
              state_o.bytes_taken   = 2'd1;
            end else begin
              emit_o          = 1'b1;
              result_o.status = ST_INVALID;
            end
          end else if (b[7:6] != 2'b10) begin
            // bad continuation byte is swallowed
            state_o         = IdleState;
            emit_o          = 1'b1;
            result_o.status = ST_INVALID;
          end else if (taken_inc == '0 || {1'b0, taken_inc} >= state_i.bytes_needed) begin
            state_o             = IdleState;
            emit_o              = 1'b1;
            result_o.code_point = cont_value;
          end else begin
            state_o.partial_value = cont_value;
            state_o.bytes_taken   = taken_inc;
          end
        end
        MODE_UTF16_LE, MODE_UTF16_BE: begin
          case (state_i.bytes_taken)
            2'd0: begin
              state_o.partial_value = {13'd0, b};
              state_o.bytes_needed  = 3'd2;
              state_o.bytes_taken   = 2'd1;
            end
            2'd1: begin
              if (unit[15:11] != 5'b11011) begin
                state_o             = IdleState;
                emit_o              = 1'b1;
                result_o.code_point = {5'd0, unit};
              end else begin
                // surrogate range: always gather a second unit
                state_o.lead_unit_high_surrogate = (unit[15:10] == 6'b110110);
                state_o.partial_value            = {11'd0, unit[9:0]};
                state_o.bytes_needed             = 3'd4;
                state_o.bytes_taken              = 2'd2;
              end
            end
            2'd2: begin
              state_o.partial_value = {state_i.partial_value[CodeW-9:0], b};
              state_o.bytes_taken   = 2'd3;
            end
            default: begin
              state_o = IdleState;
              emit_o  = 1'b1;
              if (state_i.lead_unit_high_surrogate && hi2[7:2] == 6'b110111) begin
                result_o.code_point = SuppBase +
                  {1'b0, state_i.partial_value[17:8], hi2[1:0], lo2};
              end else begin
                result_o.status = ST_INVALID;
              end
            end
          endcase
        end
        default: begin
          state_o = IdleState;
        end
      endcase
    end
  end

endmodule

FILE: hdl/multi_encoding_char_decoder.sv
// top level of the raw / utf-8 / utf-16 character decoder
// a result is registered in the output register, or in the skid entry while the output stalls
// throughput: one byte per cycle while the skid entry is empty; the per-byte decode is one combinational pass
// an output register plus one skid entry keep input flowing while a result waits
// reset: mode utf-8, decoder idle, output and skid empty; config writes always taken
module multi_encoding_char_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mecd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mecd_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_data_i
);
  import mecd_pkg::*;

  mode_e      mode_q;
  dec_state_t state_q, state_d;
  logic       step_emit;
  out_item_t  step_res;
  logic       accept;
  logic       res_valid;
  logic       out_ready;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       skid_valid_q;
  out_item_t  skid_q;

  mecd_step u_step (
    .mode_i   (mode_q),
    .state_i  (state_q),
    .item_i   (in_data_i),
    .state_o  (state_d),
    .emit_o   (step_emit),
    .result_o (step_res)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign res_valid   = accept && step_emit;
  assign out_ready   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeReset;
      state_q <= IdleState;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // a register write drops any partial sequence
      mode_q  <= mode_e'(cfg_data_i);
      state_q <= IdleState;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= step_res;
      end
    end else if (res_valid) begin
      skid_q <= step_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_end_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.end_of_data |=> state_q.bytes_taken == '0)
    else $error("decoder not idle after end of data");

  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.end_of_data |=> out_valid_q)
    else $error("end of data produced no result");

  a_raw_no_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mode_q == MODE_RAW && !(cfg_valid_i && cfg_ready_o)
      |=> state_q.bytes_taken == '0 && out_valid_q)
    else $error("raw byte left partial state or no result");

endmodule

FILE: dv/multi_encoding_char_decoder_checker.sv
// decoder prediction and result comparison for the character decoder testbench
module multi_encoding_char_decoder_checker
  import mecd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_data_i,
  output int unsigned error_count_o,
  output int unsigned pending_chars_o,
  output int unsigned results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  mode_e      enc_mode;
  dec_state_t dec;
  out_item_t  char_queue[$];

  // advances the decoder by one transfer, returns 1 when a result comes out
  function automatic bit decode_step(input in_item_t it, output out_item_t res);
    logic [ByteW-1:0] b;
    logic [15:0]      unit;
    logic [7:0]       hi2;
    logic [7:0]       lo2;
    bit               big;
    b = it.data_byte;
    res.code_point = '0;
    res.status = ST_CHAR;
    big = (enc_mode == MODE_UTF16_BE);
    if (it.end_of_data) begin
      res.status = (dec.bytes_taken == '0) ? ST_END : ST_INVALID;
      dec = IdleState;
      return 1'b1;
    end
    case (enc_mode)
      MODE_RAW: begin
        dec = IdleState;
        res.code_point = {13'd0, b};
        return 1'b1;
      end
      MODE_UTF8: begin
        if (dec.bytes_taken == '0) begin
          if (!b[7]) begin
            res.code_point = {13'd0, b};
            return 1'b1;
          end
          if (b[7:5] == 3'b110) begin
            dec.bytes_needed = 3'd2;
            dec.partial_value = {16'd0, b[4:0]};
          end else if (b[7:4] == 4'b1110) begin
            dec.bytes_needed = 3'd3;
            dec.partial_value = {17'd0, b[3:0]};
          end else if (b[7:3] == 5'b11110) begin
            dec.bytes_needed = 3'd4;
            dec.partial_value = {18'd0, b[2:0]};
          end else begin
            res.status = ST_INVALID;
            return 1'b1;
          end
          dec.bytes_taken = 2'd1;
          return 1'b0;
        end
        // the offending byte is swallowed, not retried as a lead
        if (b[7:6] != 2'b10) begin
          dec = IdleState;
          res.status = ST_INVALID;
          return 1'b1;
        end
        dec.partial_value = {dec.partial_value[14:0], b[5:0]};
        dec.bytes_taken = dec.bytes_taken + 2'd1;
        // a four byte sequence wraps the 2-bit count back to zero
        if (dec.bytes_taken == '0 || {1'b0, dec.bytes_taken} >= dec.bytes_needed) begin
          res.code_point = dec.partial_value;
          dec = IdleState;
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        case (dec.bytes_taken)
          2'd0: begin
            dec.partial_value = {13'd0, b};
            dec.bytes_needed = 3'd2;
            dec.bytes_taken = 2'd1;
            return 1'b0;
          end
          2'd1: begin
            unit = big ? {dec.partial_value[7:0], b} : {b, dec.partial_value[7:0]};
            if (unit[15:11] != 5'b11011) begin
              dec = IdleState;
              res.code_point = {5'd0, unit};
              return 1'b1;
            end
            dec.lead_unit_high_surrogate = (unit[15:10] == 6'b110110);
            dec.partial_value = {11'd0, unit[9:0]};
            dec.bytes_needed = 3'd4;
            dec.bytes_taken = 2'd2;
            return 1'b0;
          end
          2'd2: begin
            dec.partial_value = {dec.partial_value[12:0], b};
            dec.bytes_taken = 2'd3;
            return 1'b0;
          end
          default: begin
            hi2 = big ? dec.partial_value[7:0] : b;
            lo2 = big ? b : dec.partial_value[7:0];
            res.code_point = SuppBase + {1'b0, dec.partial_value[17:8], hi2[1:0], lo2};
            if (!(dec.lead_unit_high_surrogate && hi2[7:2] == 6'b110111)) begin
              res.code_point = '0;
              res.status = ST_INVALID;
            end
            dec = IdleState;
            return 1'b1;
          end
        endcase
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t res;
    if (!rst_ni) begin
      enc_mode = ModeReset;
      dec = IdleState;
      char_queue.delete();
      error_count_o = 0;
      pending_chars_o = 0;
      results_seen_o = 0;
    end else begin
      // results leave before this edge's input can have produced anything
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (char_queue.size() == 0) begin
          error_count_o++;
          $display("%0t: unexpected result, expected none, got code_point %h status %0d",
                   $time, out_data_i.code_point, out_data_i.status);
        end else begin
          want = char_queue.pop_front();
          if (out_data_i.code_point !== want.code_point) begin
            error_count_o++;
            $display("%0t: code_point mismatch, expected %h, got %h",
                     $time, want.code_point, out_data_i.code_point);
          end
          if (out_data_i.status !== want.status) begin
            error_count_o++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_data_i.status);
          end
        end
      end
      // a mode write drops any partial sequence without a result
      if (cfg_valid_i && cfg_ready_i) begin
        enc_mode = mode_e'(cfg_data_i);
        dec = IdleState;
      end
      if (in_valid_i && !in_stall_i) begin
        if (decode_step(in_data_i, res)) char_queue.push_back(res);
      end
      pending_chars_o = char_queue.size();
    end
  end

endmodule

FILE: dv/multi_encoding_char_decoder_test.sv
// testbench top: stimulus, stall patterns and verdict for the character decoder
module multi_encoding_char_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mecd_pkg::*;

  localparam int unsigned RandItems = 1700;
  localparam int unsigned PhaseItems = 110;
  localparam int unsigned DrainWait = 4;
  localparam int unsigned IdleLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = '0;

  int unsigned error_count;
  int unsigned pending_chars;
  int unsigned results_seen;
  int unsigned idle_pct = 10;
  int unsigned bytes_sent = 0;
  int unsigned rand_items = 0;
  int unsigned mode_writes = 0;

  multi_encoding_char_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  multi_encoding_char_decoder_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_i      (out_data_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .error_count_o   (error_count),
    .pending_chars_o (pending_chars),
    .results_seen_o  (results_seen)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      out_stall_i <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
    end
  end

  // no transfer on any channel for too long means the block hung
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("[multi_encoding_char_decoder] ERROR");
    $finish;
  end

  // every task below starts and returns at a falling edge
  task automatic send_item(input in_item_t it);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item('{data_byte: b, end_of_data: 1'b0});
  endtask

  // the byte lane carries junk alongside the end flag
  task automatic send_end();
    send_item('{data_byte: 8'($urandom), end_of_data: 1'b1});
  endtask

  task automatic send_unit(input logic [15:0] u, input bit big);
    if (big) begin
      send_byte(u[15:8]);
      send_byte(u[7:0]);
    end else begin
      send_byte(u[7:0]);
      send_byte(u[15:8]);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_chars != 0) @(negedge clk_i);
    // a lead byte may still be in flight with no result behind it
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic set_mode(input mode_e m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    mode_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] utf8_lead(input int unsigned len);
    case (len)
      1: return {1'b0, 7'($urandom)};
      2: return {3'b110, 5'($urandom)};
      3: return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] utf8_cont();
    return {2'b10, 6'($urandom)};
  endfunction

  task automatic utf8_chunk();
    int unsigned r;
    int unsigned len;
    logic [7:0]  b;
    r = $urandom_range(99);
    if (r < 85) begin
      len = $urandom_range(1, 4);
      send_byte(utf8_lead(len));
      repeat (len - 1) send_byte(utf8_cont());
    end else if (r < 93) begin
      // sequence cut short by a foreign byte or the end of the stream
      len = $urandom_range(2, 4);
      send_byte(utf8_lead(len));
      repeat ($urandom_range(0, len - 2)) send_byte(utf8_cont());
      if ($urandom_range(1)) begin
        send_end();
      end else begin
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        send_byte(b);
      end
    end else begin
      send_byte(8'($urandom));
    end
  endtask

  task automatic utf16_chunk(input bit big);
    int unsigned r;
    logic [15:0] u;
    r = $urandom_range(99);
    if (r < 55) begin
      u = 16'($urandom);
      if (u[15:11] == 5'b11011) u[15] = 1'b0;
      send_unit(u, big);
    end else if (r < 85) begin
      send_unit({6'b110110, 10'($urandom)}, big);
      send_unit({6'b110111, 10'($urandom)}, big);
    end else if (r < 95) begin
      // any surrogate first, any unit second
      send_unit({5'b11011, 11'($urandom)}, big);
      send_unit(16'($urandom), big);
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      send_end();
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned start;
    mode_e       m;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // utf-8 after reset: ends at idle, ascii extremes, multi-byte forms
    send_end();
    send_end();
    send_byte(8'h00);
    send_byte(8'h7f);
    send_byte(8'hc3);
    send_byte(8'ha9);
    send_byte(8'he2);
    send_byte(8'h82);
    send_byte(8'hac);
    send_byte(8'hf7);
    repeat (3) send_byte(8'hbf);
    // stray continuation and illegal lead bytes
    send_byte(8'h80);
    send_byte(8'hff);
    // broken continuation, then end inside a sequence
    send_byte(8'hc3);
    send_byte(8'h41);
    send_byte(8'he2);
    send_end();
    // left open on purpose, the mode write must drop it
    send_byte(8'hf0);
    set_mode(MODE_UTF16_LE);
    send_unit(16'hd83d, 1'b0);
    send_unit(16'hde00, 1'b0);
    set_mode(MODE_UTF16_BE);
    send_unit(16'hdc00, 1'b1);
    send_unit(16'hdc00, 1'b1);

    phase = 0;
    while (rand_items < RandItems) begin
      m = (phase < 8) ? mode_e'(phase % 4) : mode_e'($urandom_range(3));
      set_mode(m);
      idle_pct = (phase == 3) ? 0 : 10;
      start = bytes_sent;
      while (bytes_sent - start < PhaseItems) begin
        if ($urandom_range(999) < 5) drain();
        if ($urandom_range(99) < 4) begin
          send_end();
        end else begin
          case (m)
            MODE_RAW:  send_byte(8'($urandom));
            MODE_UTF8: utf8_chunk();
            default:   utf16_chunk(m == MODE_UTF16_BE);
          endcase
        end
      end
      rand_items += bytes_sent - start;
      phase++;
    end

    idle_pct = 10;
    drain();
    repeat (DrainWait) @(negedge clk_i);
    $display("stream of %0d transfers across %0d mode writes, all four encodings",
             bytes_sent, mode_writes);
    $display("%0d decoder results compared, %0d mismatches", results_seen, error_count);
    if (error_count == 0)
      $display("[multi_encoding_char_decoder] OK");
    else
      $display("[multi_encoding_char_decoder] ERROR");
    $finish;
  end

endmodule
